// File: src/lgt_pkg.sv
// ----------------------------------------------------------------------------
// lgt_pkg
// Shared constants and types for the toroidal life generation block: field
// widths, register indexes, operation codes, rule counts and controller states.
// ----------------------------------------------------------------------------
package lgt_pkg;

  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 128;

  localparam int MODE_W     = 2;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int ROWS_CFG_W = 6;
  localparam int COLS_CFG_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int CNT_W      = 4;

  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = ROWS_CFG_W'(25);
  localparam logic [COLS_CFG_W-1:0] COLS_RESET = COLS_CFG_W'(80);
  localparam int MIN_SIZE = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);

  localparam logic [MODE_W-1:0] MODE_WRITE = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_STEP  = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_READ  = MODE_W'(2);

  localparam logic [CNT_W-1:0] KEEP_COUNT  = CNT_W'(2);
  localparam logic [CNT_W-1:0] BIRTH_COUNT = CNT_W'(3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_WAIT,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

// File: src/lgt_ram.sv
// ----------------------------------------------------------------------------
// lgt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lgt_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/lgt_row_calc.sv
// ----------------------------------------------------------------------------
// lgt_row_calc
// Next state of one grid row from a three-row window, B3/S23, with horizontal
// wrap at the column count in use. Columns beyond it keep their value.
// ----------------------------------------------------------------------------
module lgt_row_calc #(
  parameter int MAX_COLS = 128
) (
  input  logic [MAX_COLS-1:0]           top,
  input  logic [MAX_COLS-1:0]           mid,
  input  logic [MAX_COLS-1:0]           bot,
  input  logic [$clog2(MAX_COLS+1)-1:0] nc,
  output logic [MAX_COLS-1:0]           nxt
);
  import lgt_pkg::*;

  localparam int NC_W  = $clog2(MAX_COLS + 1);
  localparam int COL_AW = $clog2(MAX_COLS);

  logic [COL_AW-1:0] last_idx;
  logic              top_last;
  logic              mid_last;
  logic              bot_last;

  assign last_idx = COL_AW'(nc - NC_W'(1));
  assign top_last = top[last_idx];
  assign mid_last = mid[last_idx];
  assign bot_last = bot[last_idx];

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
    logic             tl, tr, ml, mr, bl, br;
    logic [CNT_W-1:0] cnt;

    if (c == 0) begin : g_left_wrap
      assign tl = top_last;
      assign ml = mid_last;
      assign bl = bot_last;
    end else begin : g_left
      assign tl = top[c-1];
      assign ml = mid[c-1];
      assign bl = bot[c-1];
    end

    if (c == MAX_COLS - 1) begin : g_right_wrap
      assign tr = top[0];
      assign mr = mid[0];
      assign br = bot[0];
    end else begin : g_right
      logic at_end;
      assign at_end = (32'(c) + 32'd1) == 32'(nc);
      assign tr = at_end ? top[0] : top[c+1];
      assign mr = at_end ? mid[0] : mid[c+1];
      assign br = at_end ? bot[0] : bot[c+1];
    end

    assign cnt = CNT_W'(tl) + CNT_W'(top[c]) + CNT_W'(tr)
               + CNT_W'(ml) + CNT_W'(mr)
               + CNT_W'(bl) + CNT_W'(bot[c]) + CNT_W'(br);

    assign nxt[c] = (32'(c) < 32'(nc))
                  ? ((cnt == BIRTH_COUNT) || (mid[c] && (cnt == KEEP_COUNT)))
                  : mid[c];
  end

endmodule

// File: src/life_generation_torus_top.sv
// ----------------------------------------------------------------------------
// life_generation_torus_top
// Conway's Life (B3/S23) on a torus, grid held one row per RAM word.
// ----------------------------------------------------------------------------
// The grid lives in one RAM of MAX_ROWS words of MAX_COLS bits, one word per
// row, with a valid bit per row so that reset shows an all-dead grid at once
// and no clearing pass is run. A cell write or read goes from accept to result
// through a row read, a modify or select, and the result register. An advance
// sweeps the rows through a three-row window fed by the RAM read port, one row
// read and one row written back per cycle, at the pace of the RAM read port.
// A new beat is accepted once the previous operation has placed its result
// in the output register, even if that result is still waiting to be taken.
// ----------------------------------------------------------------------------
module life_generation_torus_top #(
  parameter int MAX_ROWS = lgt_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = lgt_pkg::DEF_MAX_COLS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lgt_pkg::MODE_W-1:0]   mode,
  input  logic [lgt_pkg::ROW_W-1:0]    row,
  input  logic [lgt_pkg::COL_W-1:0]    col,
  input  logic                         alive,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         cell_value,
  output logic [lgt_pkg::MODE_W-1:0]   done_mode,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lgt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lgt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lgt_pkg::*;

  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int COL_AW = $clog2(MAX_COLS);
  localparam int NR_W   = $clog2(MAX_ROWS + 1);
  localparam int NC_W   = $clog2(MAX_COLS + 1);
  localparam int K_W    = $clog2(MAX_ROWS + 2);

  state_t state, state_next;

  logic [ROWS_CFG_W-1:0] rows_cfg;
  logic [COLS_CFG_W-1:0] cols_cfg;
  logic [NR_W-1:0]       nr;
  logic [NC_W-1:0]       nc;

  logic [MODE_W-1:0] op_mode;
  logic [ROW_AW-1:0] op_row;
  logic [COL_AW-1:0] op_col;
  logic              op_alive;
  logic              op_inside;
  logic              res_value;
  logic              in_fire;
  logic              addr_in_grid;
  logic              out_free;

  logic [K_W-1:0]    k;
  logic              k_last;
  logic              d_vld;
  logic              d_mem;
  logic [K_W-1:0]    d_tag;
  logic [ROW_AW-1:0] d_addr;
  logic              w_vld;
  logic [ROW_AW-1:0] w_row;

  logic [MAX_COLS-1:0] win_top, win_mid, win_bot, row0_old, win_in;
  logic [MAX_COLS-1:0] calc_row, rd_row;
  logic [MAX_ROWS-1:0] row_vld;

  logic                ram_we;
  logic [ROW_AW-1:0]   ram_waddr, ram_raddr;
  logic [MAX_COLS-1:0] ram_wdata, ram_rdata;

  // effective grid size
  always_comb begin
    if (32'(rows_cfg) < MIN_SIZE) begin
      nr = NR_W'(MIN_SIZE);
    end else if (32'(rows_cfg) > MAX_ROWS) begin
      nr = NR_W'(MAX_ROWS);
    end else begin
      nr = NR_W'(rows_cfg);
    end
    if (32'(cols_cfg) < MIN_SIZE) begin
      nc = NC_W'(MIN_SIZE);
    end else if (32'(cols_cfg) > MAX_COLS) begin
      nc = NC_W'(MAX_COLS);
    end else begin
      nc = NC_W'(cols_cfg);
    end
  end

  assign in_ready     = (state == ST_IDLE);
  assign in_fire      = in_valid && in_ready;
  assign cfg_ready    = 1'b1;
  assign addr_in_grid = (32'(row) < 32'(nr)) && (32'(col) < 32'(nc));
  assign out_free     = !out_valid || out_ready;
  assign k_last       = (32'(k) == 32'(nr) + 32'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= ROWS_RESET;
      cols_cfg <= COLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ROWS) begin
        rows_cfg <= cfg_data[ROWS_CFG_W-1:0];
      end else if (cfg_index == REG_COLS) begin
        cols_cfg <= cfg_data[COLS_CFG_W-1:0];
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (mode == MODE_WRITE || mode == MODE_READ) begin
            state_next = ST_ROW_WAIT;
          end else if (mode == MODE_STEP) begin
            state_next = ST_SWEEP;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_ROW_WAIT: state_next = ST_FINISH;
      ST_SWEEP: begin
        if (k_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (w_vld && !d_vld) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ram access
  assign rd_row = row_vld[op_row] ? ram_rdata : '0;

  always_comb begin
    ram_raddr = ROW_AW'(row);
    if (state == ST_SWEEP) begin
      if (k == '0) begin
        ram_raddr = ROW_AW'(nr - NR_W'(1));
      end else begin
        ram_raddr = ROW_AW'(k - K_W'(1));
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = w_row;
    ram_wdata = calc_row;
    if (w_vld) begin
      ram_we = 1'b1;
    end else if (state == ST_ROW_WAIT && op_mode == MODE_WRITE && op_inside) begin
      ram_we            = 1'b1;
      ram_waddr         = op_row;
      ram_wdata         = rd_row;
      ram_wdata[op_col] = op_alive;
    end
  end

  lgt_ram #(
    .WIDTH(MAX_COLS),
    .DEPTH(MAX_ROWS)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  lgt_row_calc #(
    .MAX_COLS(MAX_COLS)
  ) u_calc (
    .top(win_top),
    .mid(win_mid),
    .bot(win_bot),
    .nc (nc),
    .nxt(calc_row)
  );

  // row valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (ram_we) begin
      row_vld[ram_waddr] <= 1'b1;
    end
  end

  // sweep pipeline: read, window shift, write back
  assign win_in = d_mem ? (row_vld[d_addr] ? ram_rdata : '0) : row0_old;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
      w_vld <= 1'b0;
      k     <= '0;
    end else begin
      d_vld <= (state == ST_SWEEP);
      w_vld <= d_vld && (32'(d_tag) >= 32'd2);
      if (in_fire) begin
        k <= '0;
      end else if (state == ST_SWEEP) begin
        k <= k + K_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    d_mem  <= !k_last;
    d_tag  <= k;
    d_addr <= ram_raddr;
    w_row  <= ROW_AW'(d_tag - K_W'(2));
    if (d_vld) begin
      win_top <= win_mid;
      win_mid <= win_bot;
      win_bot <= win_in;
      if (d_tag == K_W'(1)) begin
        row0_old <= win_in;
      end
    end
  end

  // operation and result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_mode   <= mode;
      op_row    <= ROW_AW'(row);
      op_col    <= COL_AW'(col);
      op_alive  <= alive;
      op_inside <= addr_in_grid;
      res_value <= 1'b0;
    end else if (state == ST_ROW_WAIT && op_mode == MODE_READ) begin
      res_value <= op_inside && rd_row[op_col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      cell_value <= res_value;
      done_mode  <= op_mode;
    end
  end

endmodule

// File: dv/life_generation_torus_top_test.sv
// ----------------------------------------------------------------------------
// life_generation_torus_top_test
// Self-checking bench for the toroidal life block. A queue-fed driver offers
// cell writes, cell reads and generation steps in bursts, and the result side
// stalls on a pattern of its own. A behavioral copy of the grid predicts every
// result beat. The run steps through several grid sizes, the clamped ones too.
// ----------------------------------------------------------------------------
module life_generation_torus_top_test;
  import lgt_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE = MODE_W'(3);
  localparam int ITEMS_TOTAL    = 1400;
  localparam int PHASE_ITEMS    = 110;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 250;
  localparam int N_FIXED        = 8;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              alive;
  } cell_op_t;

  typedef struct packed {
    logic              cell_value;
    logic [MODE_W-1:0] done_mode;
  } cell_result_t;

  typedef enum {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_style_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [MODE_W-1:0]     mode       = '0;
  logic [ROW_W-1:0]      row        = '0;
  logic [COL_W-1:0]      col        = '0;
  logic                  alive      = 1'b0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic                  cell_value;
  logic [MODE_W-1:0]     done_mode;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  logic [ROWS_CFG_W-1:0] rows_cfg = ROWS_RESET;
  logic [COLS_CFG_W-1:0] cols_cfg = COLS_RESET;
  bit [DEF_MAX_COLS-1:0] life_grid [DEF_MAX_ROWS];
  bit [DEF_MAX_COLS-1:0] step_grid [DEF_MAX_ROWS];

  cell_op_t     cell_ops[$];
  cell_result_t pending_results[$];
  int           items_queued = 0;
  int           in_beats = 0;
  int           mismatches = 0;
  logic         in_beat = 1'b0;
  int           gap_left = 0;
  int           burst_left = 0;
  int           rx_hold_left = 0;
  int           holds_done = 0;
  int           rx_pattern_left = 0;
  rx_style_t    rx_style = RX_ALWAYS;
  int           idle_cycles;

  life_generation_torus_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .row        (row),
    .col        (col),
    .alive      (alive),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cell_value (cell_value),
    .done_mode  (done_mode),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
  end

  function automatic int grid_extent(int v, int maxv);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void life_step(int nr, int nc);
    int r, c, up, dn, lf, rt, n;
    for (r = 0; r < nr; r++) begin
      up = (r + nr - 1) % nr;
      dn = (r + 1) % nr;
      for (c = 0; c < nc; c++) begin
        lf = (c + nc - 1) % nc;
        rt = (c + 1) % nc;
        n = life_grid[up][lf] + life_grid[up][c] + life_grid[up][rt]
          + life_grid[r][lf] + life_grid[r][rt]
          + life_grid[dn][lf] + life_grid[dn][c] + life_grid[dn][rt];
        step_grid[r][c] = (n == BIRTH_COUNT) || (life_grid[r][c] && n == KEEP_COUNT);
      end
    end
    for (r = 0; r < nr; r++)
      for (c = 0; c < nc; c++)
        life_grid[r][c] = step_grid[r][c];
  endfunction

  function automatic cell_result_t predict_beat(cell_op_t op);
    cell_result_t res;
    int nr, nc;
    logic in_grid;
    nr = grid_extent(int'(rows_cfg), DEF_MAX_ROWS);
    nc = grid_extent(int'(cols_cfg), DEF_MAX_COLS);
    in_grid = (op.row < nr) && (op.col < nc);
    res.cell_value = 1'b0;
    res.done_mode = op.mode;
    case (op.mode)
      MODE_WRITE: if (in_grid) life_grid[op.row][op.col] = op.alive;
      MODE_STEP:  life_step(nr, nc);
      MODE_READ:  if (in_grid) res.cell_value = life_grid[op.row][op.col];
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < 30)
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic add_op(logic [MODE_W-1:0] m, int r, int c, logic a);
    cell_op_t op;
    op.mode = m;
    op.row = ROW_W'(r);
    op.col = COL_W'(c);
    op.alive = a;
    cell_ops.push_back(op);
    items_queued++;
  endtask

  // seed a patch near a random spot, step it a few times and read it back
  task automatic add_life_run(int nr, int nc);
    int span_r, span_c, base_r, base_c, r, c;
    span_r = (nr < 6) ? nr : 6;
    span_c = (nc < 8) ? nc : 8;
    base_r = $urandom_range(0, nr - 1);
    base_c = $urandom_range(0, nc - 1);
    repeat ($urandom_range(3, span_r * span_c / 2 + 2)) begin
      r = (base_r + $urandom_range(0, span_r - 1)) % nr;
      c = (base_c + $urandom_range(0, span_c - 1)) % nc;
      add_op(MODE_WRITE, r, c, $urandom_range(0, 4) != 0);
    end
    repeat ($urandom_range(1, 3)) begin
      add_op(MODE_STEP, $urandom_range(0, 31), $urandom_range(0, 127),
             1'($urandom_range(0, 1)));
      if (nr * nc <= 48 && $urandom_range(0, 1)) begin
        for (r = 0; r < nr; r++)
          for (c = 0; c < nc; c++)
            add_op(MODE_READ, r, c, 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(2, 6)) begin
          r = (base_r + nr - 1 + $urandom_range(0, span_r + 1)) % nr;
          c = (base_c + nc - 1 + $urandom_range(0, span_c + 1)) % nc;
          add_op(MODE_READ, r, c, 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  task automatic add_noise();
    repeat ($urandom_range(1, 6))
      add_op(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 31),
             $urandom_range(0, 127), 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (cell_ops.size() != 0 || in_valid || pending_results.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == REG_ROWS) rows_cfg = data[ROWS_CFG_W-1:0];
    else cols_cfg = data[COLS_CFG_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // input driver
  always @(negedge clk) begin : driver
    cell_op_t op;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_beat) begin
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (cell_ops.size() > 0) begin
      op = cell_ops.pop_front();
      in_valid <= 1'b1;
      mode <= op.mode;
      row <= op.row;
      col <= op.col;
      alive <= op.alive;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side stalls, with a long hold-off now and then
  always @(negedge clk) begin : receiver
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (holds_done < 2 && in_beats >= 300 + 600 * holds_done) begin
      holds_done++;
      rx_hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (rx_pattern_left == 0) begin
        rx_style = rx_style_t'($urandom_range(0, 3));
        rx_pattern_left = $urandom_range(16, 96);
      end else begin
        rx_pattern_left--;
      end
      case (rx_style)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ~out_ready;
      endcase
    end
  end

  // predict on input beats, check on output beats
  always @(posedge clk) begin : monitor
    cell_result_t want;
    in_beat = in_valid && in_ready && !rst;
    if (in_beat) begin
      in_beats++;
      pending_results.push_back(predict_beat({mode, row, col, alive}));
    end
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with none expected, done_mode", int'(done_mode), -1);
      end else begin
        want = pending_results.pop_front();
        if (cell_value !== want.cell_value)
          report_mismatch("cell_value", int'(cell_value), int'(want.cell_value));
        if (done_mode !== want.done_mode)
          report_mismatch("done_mode", int'(done_mode), int'(want.done_mode));
      end
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] fixed_rows [N_FIXED];
    logic [CFG_DATA_W-1:0] fixed_cols [N_FIXED];
    logic [CFG_DATA_W-1:0] rows_data, cols_data;
    int phase, phase_start;
    fixed_rows = '{8'd3, 8'd0, 8'd32, 8'hFF, 8'hC5, 8'd4, 8'd8, 8'd1};
    fixed_cols = '{8'd3, 8'd0, 8'd128, 8'hFF, 8'd10, 8'd2, 8'd16, 8'd127};

    // reset size 25 x 80: blinker across both wraps, out-of-grid cells, undefined mode
    add_op(MODE_READ, 0, 0, 0);
    add_op(MODE_READ, 31, 127, 1);
    add_op(MODE_WRITE, 24, 79, 1);
    add_op(MODE_WRITE, 0, 79, 1);
    add_op(MODE_WRITE, 1, 79, 1);
    add_op(MODE_WRITE, 25, 0, 1);
    add_op(MODE_WRITE, 0, 80, 1);
    add_op(MODE_WRITE, 31, 127, 1);
    add_op(MODE_NONE, 31, 127, 1);
    add_op(MODE_READ, 0, 79, 0);
    add_op(MODE_STEP, 0, 0, 0);
    add_op(MODE_READ, 0, 78, 0);
    add_op(MODE_READ, 0, 0, 0);
    add_op(MODE_READ, 24, 79, 0);
    add_op(MODE_READ, 25, 0, 0);
    add_op(MODE_STEP, 31, 127, 1);
    add_op(MODE_READ, 1, 79, 0);
    add_op(MODE_WRITE, 1, 79, 0);
    add_op(MODE_READ, 1, 79, 1);
    add_op(MODE_NONE, 0, 0, 0);
    wait_drained();

    phase = 0;
    while (items_queued < ITEMS_TOTAL) begin
      if (phase < N_FIXED) begin
        rows_data = fixed_rows[phase];
        cols_data = fixed_cols[phase];
      end else begin
        rows_data = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(0, 255))
                                                : CFG_DATA_W'($urandom_range(3, 10));
        cols_data = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(0, 255))
                                                : CFG_DATA_W'($urandom_range(3, 24));
      end
      write_reg(REG_ROWS, rows_data);
      write_reg(REG_COLS, cols_data);
      phase_start = items_queued;
      while (items_queued - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 6) != 0)
          add_life_run(grid_extent(int'(rows_cfg), DEF_MAX_ROWS),
                       grid_extent(int'(cols_cfg), DEF_MAX_COLS));
        else
          add_noise();
      end
      wait_drained();
      phase++;
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
